// ----- src/upc_pkg.sv -----
`timescale 1ns / 1ps

package upc_pkg;

    localparam int BYTE_W = 8;
    localparam int MAX_RES = 3;
    localparam int CNT_W = 2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Decode phase codes.
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        t_result [MAX_RES-1:0] ent;
    } t_group;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [BYTE_W-1:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic passes_plain(input logic [BYTE_W-1:0] c);
        return is_digit(c) || is_upper(c) || is_lower(c) || (c == CH_DASH) ||
               (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
    endfunction

    // Lowercase hex character for one nibble.
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'd0, n};
        end else begin
            return 8'h57 + {4'd0, n};
        end
    endfunction

    // Digit value modulo 256; any byte is taken as a digit.
    function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] lc;
        lc = is_upper(c) ? (c + 8'h20) : c;
        if (is_digit(c)) begin
            return c - 8'h30;
        end else begin
            return lc - 8'h57;
        end
    endfunction

endpackage

// ----- src/url_percent_codec_core.sv -----
`timescale 1ns / 1ps

// URL form codec core.
// The input channel (i_valid / o_ready) carries one request per string byte,
// with i_in_last marking the final byte. The output channel (o_valid /
// i_ready) carries converted bytes; o_out_valid is 0 on an empty end marker,
// sent when the final byte of a string yields no data, and o_out_last flags
// the final result of each string.
// The mode register is written through i_cfg_we / i_cfg_wdata (0 encode,
// 1 decode); the user must write it only while the block is idle, and the
// block itself has no check for this. A write also drops any pending escape.
// An accepted request is held in the input register, and its results are
// loaded into the output register once it can take them; results are offered from there.
// Throughput is one request per cycle while the receiver takes every result,
// except that an encoded escape emits three bytes through the single output
// register, so such a byte holds the input until those bytes have drained.
// When the receiver stalls, the output register holds its result and the
// input register fills, after which o_ready drops until the output drains.
// Synchronous active-low reset selects encode mode, clears the pending
// escape and empties both registers.
module url_percent_codec_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_out_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);
    import upc_pkg::*;

    logic              r_mode;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              out_free;
    logic              advance;
    logic              accept;
    t_group            group;
    t_result           res;

    // The held request moves on once the output register can take its results.
    assign advance = r_in_vld && out_free;
    assign o_ready = !r_in_vld || out_free;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    upc_convert u_convert (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_clear   (i_cfg_we),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_group   (group)
    );

    upc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_group (group),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_out_byte  = res.data;
    assign o_out_valid = res.valid;
    assign o_out_last  = res.last;

endmodule

// ----- src/upc_convert.sv -----
`timescale 1ns / 1ps

module upc_convert (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mode,
    input  logic                 i_clear,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output upc_pkg::t_group      o_group
);
    import upc_pkg::*;

    logic [1:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_held, n_held;
    t_group            grp;
    logic [BYTE_W-1:0] hi_v, lo_v;

    always_comb begin
        hi_v    = digit_value(r_held);
        lo_v    = digit_value(i_byte);
        grp     = '0;
        n_phase = r_phase;
        n_held  = r_held;
        if (i_mode == MODE_ENCODE) begin
            if (passes_plain(i_byte)) begin
                grp.count  = 2'd1;
                grp.ent[0] = '{data: i_byte, valid: 1'b1, last: i_last};
            end else if (i_byte == CH_SPACE) begin
                grp.count  = 2'd1;
                grp.ent[0] = '{data: CH_PLUS, valid: 1'b1, last: i_last};
            end else begin
                grp.count  = 2'd3;
                grp.ent[0] = '{data: CH_PCT, valid: 1'b1, last: 1'b0};
                grp.ent[1] = '{data: hex_char(i_byte[7:4]), valid: 1'b1, last: 1'b0};
                grp.ent[2] = '{data: hex_char(i_byte[3:0]), valid: 1'b1, last: i_last};
            end
        end else if ((r_phase == PH_PCT) && !i_last) begin
            n_held  = i_byte;
            n_phase = PH_HIGH;
        end else if (r_phase == PH_HIGH) begin
            grp.count  = 2'd1;
            grp.ent[0] = '{data: {hi_v[3:0], 4'd0} | lo_v, valid: 1'b1, last: i_last};
            n_phase    = PH_NONE;
            n_held     = '0;
        end else begin
            // Ordinary byte; also a '%' cut short by the end of the string.
            n_phase = PH_NONE;
            n_held  = '0;
            if (i_byte == CH_PCT) begin
                if (!i_last) begin
                    n_phase = PH_PCT;
                end else begin
                    grp.count  = 2'd1;
                    grp.ent[0] = '{data: '0, valid: 1'b0, last: 1'b1};
                end
            end else if (i_byte == CH_PLUS) begin
                grp.count  = 2'd1;
                grp.ent[0] = '{data: CH_SPACE, valid: 1'b1, last: i_last};
            end else begin
                grp.count  = 2'd1;
                grp.ent[0] = '{data: i_byte, valid: 1'b1, last: i_last};
            end
        end
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_NONE;
            r_held  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ----- src/upc_out_buf.sv -----
`timescale 1ns / 1ps

module upc_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  upc_pkg::t_group i_group,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output upc_pkg::t_result o_res
);
    import upc_pkg::*;

    logic [CNT_W-1:0]      r_rem, n_rem;
    t_result [MAX_RES-1:0] r_ent, n_ent;
    logic                  take;

    assign take    = (r_rem != '0) && i_ready;
    assign o_free  = (r_rem == '0) || ((r_rem == 2'd1) && i_ready);
    assign o_valid = (r_rem != '0);
    assign o_res   = r_ent[0];

    always_comb begin
        n_rem = r_rem;
        n_ent = r_ent;
        if (take) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                n_ent[k] = r_ent[k+1];
            end
            n_rem = r_rem - 2'd1;
        end
        if (i_load) begin
            n_ent = i_group.ent;
            n_rem = i_group.count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the URL form codec core.
// The requests of each string are driven on the input channel. On acceptance a
// local model of the codec works out the bytes that request should produce,
// and those bytes are queued in order. Every byte that leaves the output
// channel is checked field by field against the head of that queue.
module tb;

    import upc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // Cycles for a request that produces nothing, such as a pending escape,
    // to clear both DUT registers before the mode is changed.
    localparam int SETTLE_CYC = 4;
    localparam int TAIL_CYC = 8;
    localparam int IDLE_PCT = 30;
    localparam int PHASE_REQS = 50;
    localparam int NUM_PHASES = 8;

    // Directed rows either change the mode, send a byte whose result comes
    // from the model, or send a byte whose result is written out by hand.
    typedef enum logic [1:0] {
        ROW_MODE,
        ROW_PRED,
        ROW_TYPED
    } t_row_kind;

    // For typed rows, n is the number of results and e0..e2 their bytes.
    // The marker flag stands for the empty end marker.
    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  val;
        logic        last;
        logic [1:0]  n;
        logic        marker;
        logic [7:0]  e0;
        logic [7:0]  e1;
        logic [7:0]  e2;
    } t_dir_row;

    localparam int DIR_ROWS = 27;
    localparam t_dir_row DIR_TBL [DIR_ROWS] = '{
        // Encode mode after reset.
        '{ROW_TYPED, 8'h41, 1'b0, 2'd1, 1'b0, 8'h41, 8'h00, 8'h00}, // 'A' passes
        '{ROW_TYPED, 8'h7A, 1'b0, 2'd1, 1'b0, 8'h7A, 8'h00, 8'h00}, // 'z' passes
        '{ROW_TYPED, 8'h7E, 1'b0, 2'd1, 1'b0, 8'h7E, 8'h00, 8'h00}, // '~' passes
        '{ROW_TYPED, 8'h20, 1'b0, 2'd1, 1'b0, 8'h2B, 8'h00, 8'h00}, // space to '+'
        '{ROW_TYPED, 8'h00, 1'b0, 2'd3, 1'b0, 8'h25, 8'h30, 8'h30}, // lowest byte
        '{ROW_TYPED, 8'hFF, 1'b1, 2'd3, 1'b0, 8'h25, 8'h66, 8'h66}, // highest byte
        '{ROW_PRED,  8'h2F, 1'b1, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00}, // '/'
        '{ROW_PRED,  8'h80, 1'b1, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00}, // non-ASCII
        // Decode mode.
        '{ROW_MODE,  8'(MODE_DECODE), 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{ROW_TYPED, 8'h2B, 1'b0, 2'd1, 1'b0, 8'h20, 8'h00, 8'h00}, // '+' to space
        '{ROW_TYPED, 8'h25, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00}, // "%41"
        '{ROW_TYPED, 8'h34, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{ROW_TYPED, 8'h31, 1'b0, 2'd1, 1'b0, 8'h41, 8'h00, 8'h00},
        '{ROW_TYPED, 8'h25, 1'b1, 2'd1, 1'b1, 8'h00, 8'h00, 8'h00}, // '%' ends string
        '{ROW_TYPED, 8'h25, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00}, // one byte left
        '{ROW_TYPED, 8'h67, 1'b1, 2'd1, 1'b0, 8'h67, 8'h00, 8'h00},
        '{ROW_TYPED, 8'h25, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00}, // "%%" at the end
        '{ROW_TYPED, 8'h25, 1'b1, 2'd1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{ROW_TYPED, 8'h25, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00}, // non-hex digits
        '{ROW_PRED,  8'h7A, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{ROW_PRED,  8'h5A, 1'b1, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00},
        // A mode write drops the pending escape, so "41" passes through.
        '{ROW_TYPED, 8'h25, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{ROW_MODE,  8'(MODE_DECODE), 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{ROW_TYPED, 8'h34, 1'b0, 2'd1, 1'b0, 8'h34, 8'h00, 8'h00},
        '{ROW_TYPED, 8'h31, 1'b1, 2'd1, 1'b0, 8'h31, 8'h00, 8'h00},
        '{ROW_PRED,  8'h00, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{ROW_PRED,  8'hFF, 1'b1, 2'd0, 1'b0, 8'h00, 8'h00, 8'h00}
    };

    // Mode of each random phase. The third and seventh phases run with no
    // idling on either side.
    localparam logic PHASE_MODE [NUM_PHASES] = '{
        MODE_ENCODE, MODE_DECODE, MODE_DECODE, MODE_ENCODE,
        MODE_DECODE, MODE_ENCODE, MODE_ENCODE, MODE_DECODE
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic       o_out_last;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;

    // When set, neither the sender nor the receiver idles.
    logic steady = 1'b0;

    // Local copy of the codec state.
    logic       codec_mode = MODE_ENCODE;
    logic [1:0] esc_phase = PH_NONE;
    logic [7:0] esc_high = 8'h00;

    // Converted bytes still owed by the DUT, oldest first.
    t_result pending_bytes[$];

    int mismatches = 0;
    int cycle_cnt = 0;
    int n_requests = 0;
    int n_strings = 0;
    int n_checked = 0;
    int n_mode_writes = 0;

    logic [7:0] str_bytes[$];

    url_percent_codec_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Letters, digits and the four marks - _ . ~ are left as they are.
    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == CH_DASH || c == CH_UNDER ||
               c == CH_DOT || c == CH_TILDE;
    endfunction

    // Hex character for a nibble, in either case.
    function automatic logic [7:0] nib_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) begin
            return "0" + 8'(n);
        end
        return (upper ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    // Value of one escape digit. Any byte is taken, and values wrap modulo 256.
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c - "0";
        end
        if (c >= "A" && c <= "Z") begin
            c = c + 8'd32;
        end
        return c - "a" + 8'd10;
    endfunction

    function automatic void add_byte(inout t_group g, input logic [7:0] b,
                                     input logic v, input logic l);
        g.ent[g.count].data = b;
        g.ent[g.count].valid = v;
        g.ent[g.count].last = l;
        g.count = g.count + 1'b1;
    endfunction

    // Appends one byte to the string being built.
    function automatic void add_str_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    // Advances the local codec state by one request and returns the bytes
    // that request produces.
    function automatic t_group codec_step(input logic [7:0] b, input logic l);
        t_group g;
        logic [7:0] hi;
        logic [7:0] lo;
        g = '0;
        if (codec_mode == MODE_ENCODE) begin
            if (is_unreserved(b)) begin
                add_byte(g, b, 1'b1, l);
            end else if (b == CH_SPACE) begin
                add_byte(g, CH_PLUS, 1'b1, l);
            end else begin
                add_byte(g, CH_PCT, 1'b1, 1'b0);
                add_byte(g, nib_char(b[7:4], 1'b0), 1'b1, 1'b0);
                add_byte(g, nib_char(b[3:0], 1'b0), 1'b1, l);
            end
            return g;
        end
        // The high digit is held only when a low digit can still follow.
        if (esc_phase == PH_PCT && !l) begin
            esc_high = b;
            esc_phase = PH_HIGH;
            return g;
        end
        if (esc_phase == PH_HIGH) begin
            hi = digit_of(esc_high);
            lo = digit_of(b);
            add_byte(g, {hi[3:0], 4'h0} | lo, 1'b1, l);
            esc_phase = PH_NONE;
            esc_high = 8'h00;
            return g;
        end
        // Plain byte, or a '%' that arrives as the last byte of its string.
        esc_phase = PH_NONE;
        esc_high = 8'h00;
        if (b == CH_PCT) begin
            if (!l) begin
                esc_phase = PH_PCT;
            end else begin
                add_byte(g, 8'h00, 1'b0, 1'b1);
            end
        end else if (b == CH_PLUS) begin
            add_byte(g, CH_SPACE, 1'b1, l);
        end else begin
            add_byte(g, b, 1'b1, l);
        end
        return g;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Sends one request. Valid is only lowered when the sender idles, so a
    // request that follows straight on keeps valid high across the edge.
    // With typed set, the hand-written results replace the model's.
    task automatic send_req(input logic [7:0] b, input logic l,
                            input logic typed, input t_group want);
        t_group g;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        g = codec_step(b, l);
        if (typed) begin
            g = want;
        end
        for (int i = 0; i < int'(g.count); i++) begin
            pending_bytes.insert(pending_bytes.size(), g.ent[i]);
        end
        n_requests++;
        if (l) begin
            n_strings++;
        end
    endtask

    // The mode is only changed with nothing in flight: every owed byte has
    // come out and any request that produces nothing has had time to clear.
    task automatic write_mode(input logic m);
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        codec_mode = m;
        esc_phase = PH_NONE;
        esc_high = 8'h00;
        n_mode_writes++;
    endtask

    // Builds one random string. Encoding takes any byte, biased toward
    // printable text. Decoding mostly gets well-formed text with escapes of
    // either digit case, and now and then noise full of stray '%' bytes.
    task automatic make_string(input logic m);
        logic [7:0] b;
        int parts;
        int r;
        logic clean;
        str_bytes.delete();
        parts = $urandom_range(1, 6);
        clean = ($urandom_range(99) < 80);
        for (int p = 0; p < parts; p++) begin
            r = $urandom_range(99);
            b = 8'($urandom_range(255));
            if (m == MODE_ENCODE) begin
                if (r < 40) begin
                    b = 8'($urandom_range(8'h20, 8'h7E));
                end else if (r < 50) begin
                    b = CH_SPACE;
                end
                add_str_byte(b);
            end else if (clean) begin
                if (r < 40) begin
                    add_str_byte(CH_PCT);
                    add_str_byte(nib_char(4'($urandom_range(15)), 1'($urandom)));
                    add_str_byte(nib_char(4'($urandom_range(15)), 1'($urandom)));
                end else if (r < 55) begin
                    add_str_byte(CH_PLUS);
                end else begin
                    add_str_byte(b == CH_PCT ? CH_DOT : b);
                end
            end else begin
                add_str_byte(r < 30 ? CH_PCT : b);
            end
        end
    endtask

    // The receiver stalls at random, except in the steady phases.
    always @(posedge i_clk) begin
        i_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // The output handshake is sampled on the falling edge, where valid, ready
    // and the payload already hold the values that the next rising edge sees.
    // The request behind any legal result was accepted, and its bytes queued,
    // at an earlier rising edge.
    always @(negedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h valid %0b last %0b",
                                          o_out_byte, o_out_valid, o_out_last));
            end else begin
                want = pending_bytes.pop_front();
                n_checked++;
                if (o_out_byte !== want.data) begin
                    report_mismatch($sformatf("byte %02h, wanted %02h",
                                              o_out_byte, want.data));
                end
                if (o_out_valid !== want.valid) begin
                    report_mismatch($sformatf("data flag %0b, wanted %0b",
                                              o_out_valid, want.valid));
                end
                if (o_out_last !== want.last) begin
                    report_mismatch($sformatf("last flag %0b, wanted %0b",
                                              o_out_last, want.last));
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still owed",
                     cycle_cnt, pending_bytes.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_dir_row row;
        t_group want;
        int phase_start;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: the model decides the ROW_PRED rows, the others
        // carry their results by hand.
        for (int k = 0; k < DIR_ROWS; k++) begin
            row = DIR_TBL[k];
            if (row.kind == ROW_MODE) begin
                write_mode(row.val[0]);
            end else begin
                want = '0;
                want.count = row.n;
                for (int i = 0; i < int'(row.n); i++) begin
                    want.ent[i].data = (i == 0) ? row.e0 : (i == 1) ? row.e1 : row.e2;
                    want.ent[i].valid = !row.marker;
                    want.ent[i].last = (i == int'(row.n) - 1) ? row.last : 1'b0;
                end
                send_req(row.val, row.last, row.kind == ROW_TYPED, want);
            end
        end

        // Random strings, one phase per mode setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mode(PHASE_MODE[p]);
            steady <= (p == 2 || p == 6);
            phase_start = n_requests;
            while (n_requests - phase_start < PHASE_REQS) begin
                make_string(PHASE_MODE[p]);
                for (int i = 0; i < str_bytes.size(); i++) begin
                    send_req(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
                end
            end
        end

        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("Sent %0d requests in %0d strings over %0d mode writes, both directions.",
                 n_requests, n_strings, n_mode_writes);
        $display("Checked %0d converted bytes, %0d mismatches.", n_checked, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
